// ===== rtl/sps_pkg.sv =====
// sps_pkg: shared types and constants of the sensor poll/scan sequencer
// no dependencies; used by sps_if.sv, sps_status_map.sv and the top level

package sps_pkg;

	// sizing
	localparam int NUM_SENSORS   = 64;
	localparam int TIMEOUT_TICKS = 100;
	localparam int IDX_W         = 6;
	localparam int CUR_W         = 7;
	localparam int CNT_W         = 8;

	// request actions
	localparam logic [2:0] ACT_MEASURE = 3'd0;
	localparam logic [2:0] ACT_POLL    = 3'd1;
	localparam logic [2:0] ACT_INIT    = 3'd2;
	localparam logic [2:0] ACT_RESP    = 3'd3;
	localparam logic [2:0] ACT_LOAD    = 3'd4;

	// result events
	localparam logic [2:0] EV_NONE         = 3'd0;
	localparam logic [2:0] EV_MEAS_CMD     = 3'd1;
	localparam logic [2:0] EV_DATA         = 3'd2;
	localparam logic [2:0] EV_MEAS_TIMEOUT = 3'd3;
	localparam logic [2:0] EV_SCAN_END     = 3'd4;
	localparam logic [2:0] EV_POLL_CMD     = 3'd5;
	localparam logic [2:0] EV_POLL_FAIL    = 3'd6;
	localparam logic [2:0] EV_POLL_DONE    = 3'd7;

	// sensor status codes
	localparam logic [1:0] ST_ABSENT  = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;

	// error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_POLL_FAIL = 2'd1;
	localparam logic [1:0] ERR_MEAS_TO   = 2'd2;

	// reset value of the scan interval register
	localparam logic [CNT_W-1:0] SCAN_INTERVAL_RST = 8'd10;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SRCH,
		S_CHK,
		S_DONE
	} state_t;

	// status map control from the sequencer
	typedef struct packed {
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [1:0]       wr_data;
		logic             clr_en;
		logic [IDX_W-1:0] clr_addr;
	} map_ctrl_t;

endpackage

// ===== rtl/sps_if.sv =====
// sps_req_if / sps_rsp_if: valid/ready channels for requests and results
// depends on sps_pkg for field widths

interface sps_req_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               action;
	logic                     tick_1s;
	logic                     tick_10ms;
	logic                     tx_busy;
	logic                     response_value;
	logic [sps_pkg::IDX_W-1:0] load_index;
	logic [1:0]               load_status;

	modport source (
		output valid, action, tick_1s, tick_10ms, tx_busy, response_value,
		       load_index, load_status,
		input  ready
	);
	modport sink (
		input  valid, action, tick_1s, tick_10ms, tx_busy, response_value,
		       load_index, load_status,
		output ready
	);
endinterface

interface sps_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               event_res;
	logic [sps_pkg::IDX_W-1:0] sensor_index;
	logic [1:0]               error_code;
	logic                     scanning;

	modport source (
		output valid, event_res, sensor_index, error_code, scanning,
		input  ready
	);
	modport sink (
		input  valid, event_res, sensor_index, error_code, scanning,
		output ready
	);
endinterface

// ===== rtl/sps_status_map.sv =====
// sps_status_map: per-sensor status memory with valid bits, registered read
// depends on sps_pkg (map_ctrl_t, sizes, status codes)

module sps_status_map (
	input  logic               clk,
	input  logic               arst_n,
	input  sps_pkg::map_ctrl_t ctrl,
	output logic [1:0]         status
);

	logic [1:0]                     mem [sps_pkg::NUM_SENSORS];
	logic [sps_pkg::NUM_SENSORS-1:0] valid_q;
	logic [1:0]                     rd_data_q;
	logic                           rd_vld_q;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= ctrl.wr_data;
		end
		rd_data_q <= mem[ctrl.rd_addr];
	end

	// valid bits: an entry never loaded or marked absent reads as absent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctrl.wr_en) begin
				valid_q[ctrl.wr_addr] <= 1'b1;
			end
			if (ctrl.clr_en) begin
				valid_q[ctrl.clr_addr] <= 1'b0;
			end
			rd_vld_q <= valid_q[ctrl.rd_addr];
		end
	end

	assign status = rd_vld_q ? rd_data_q : sps_pkg::ST_ABSENT;

endmodule

// ===== rtl/sensor_poll_scan_sequencer.sv =====
// sensor_poll_scan_sequencer: top level, step sequencer around the status map
// depends on sps_pkg, sps_if.sv (sps_req_if, sps_rsp_if), sps_status_map
// flow: each accepted request runs through EXEC, an optional map search (SRCH, then CHK once
// per status entry checked) and DONE into the result register; one request at a time, the next
// taken only back in IDLE, which DONE holds off while a result waits.
// reset: map reads all absent, counters and flags clear, interval and its countdown 10.

module sensor_poll_scan_sequencer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [sps_pkg::CNT_W-1:0]    cfg_wr_data,
	sps_req_if.sink                      req,
	sps_rsp_if.source                    rsp
);

	localparam logic [sps_pkg::CUR_W-1:0] NUM_S = sps_pkg::CUR_W'(sps_pkg::NUM_SENSORS);
	localparam logic [sps_pkg::CNT_W-1:0] TMO   = sps_pkg::CNT_W'(sps_pkg::TIMEOUT_TICKS);

	sps_pkg::state_t state_q, state_d;

	// latched request
	logic [2:0]                  act_q;
	logic                        t1s_q, t10ms_q, busy_q, resp_val_q;
	logic [sps_pkg::IDX_W-1:0]   lidx_q;
	logic [1:0]                  lst_q;

	// sequencer state
	logic [sps_pkg::CNT_W-1:0]   scan_interval_q;
	logic [sps_pkg::CUR_W-1:0]   cur_q, cur_d;
	logic [sps_pkg::CNT_W-1:0]   int_q, int_d;
	logic                        scan_q, scan_d;
	logic                        awm_q, awm_d;
	logic [sps_pkg::CNT_W-1:0]   mwc_q, mwc_d;
	logic                        awp_q, awp_d;
	logic [sps_pkg::CNT_W-1:0]   pwc_q, pwc_d;
	logic [1:0]                  retry_q, retry_d;
	logic                        rlat_q, rlat_d;
	logic [1:0]                  err_q, err_d;
	logic [2:0]                  ev_q, ev_d;
	logic [sps_pkg::IDX_W-1:0]   idx_q, idx_d;

	// result register
	logic                        out_valid_q;
	logic [2:0]                  out_ev_q;
	logic [sps_pkg::IDX_W-1:0]   out_idx_q;
	logic [1:0]                  out_err_q;
	logic                        out_scan_q;

	sps_pkg::map_ctrl_t          map_ctrl;
	logic [1:0]                  map_status;

	logic                        accept, out_free, srch_go;
	logic [sps_pkg::CNT_W-1:0]   ic_dec, ic_new;
	logic                        t1s_fire, sa_new;
	logic [sps_pkg::CUR_W-1:0]   cs_new, cs_inc, cur_inc;
	logic [sps_pkg::CNT_W-1:0]   mwc_inc, pwc_inc;
	logic [1:0]                  retry_inc;
	logic                        skip;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == sps_pkg::S_IDLE);

	// interval countdown for a measure step
	assign ic_dec   = int_q - 1'b1;
	assign t1s_fire = t1s_q && (ic_dec == '0);
	assign ic_new   = !t1s_q ? int_q : (t1s_fire ? scan_interval_q : ic_dec);
	assign sa_new   = scan_q || t1s_fire;
	assign cs_new   = t1s_fire ? '0 : cur_q;
	assign cs_inc   = cs_new + 1'b1;
	assign cur_inc  = cur_q + 1'b1;
	assign mwc_inc  = mwc_q + 1'b1;
	assign pwc_inc  = pwc_q + 1'b1;
	assign retry_inc = retry_q + 1'b1;

	// search skip test on the status just read
	assign skip = (act_q == sps_pkg::ACT_MEASURE) ? (map_status == sps_pkg::ST_ABSENT)
	                                              : (map_status != sps_pkg::ST_PRESENT);

	sps_status_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (map_ctrl),
		.status (map_status)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sps_pkg::S_IDLE: if (req.valid) state_d = sps_pkg::S_EXEC;
			sps_pkg::S_EXEC: state_d = srch_go ? sps_pkg::S_SRCH : sps_pkg::S_DONE;
			sps_pkg::S_SRCH: state_d = (cur_q < NUM_S) ? sps_pkg::S_CHK : sps_pkg::S_DONE;
			sps_pkg::S_CHK:  state_d = (skip && (cur_inc < NUM_S)) ? sps_pkg::S_CHK
			                                                        : sps_pkg::S_DONE;
			sps_pkg::S_DONE: if (out_free) state_d = sps_pkg::S_IDLE;
			default:         state_d = sps_pkg::S_IDLE;
		endcase
	end

	// step datapath and map control
	always_comb begin
		cur_d   = cur_q;
		int_d   = int_q;
		scan_d  = scan_q;
		awm_d   = awm_q;
		mwc_d   = mwc_q;
		awp_d   = awp_q;
		pwc_d   = pwc_q;
		retry_d = retry_q;
		rlat_d  = rlat_q;
		err_d   = err_q;
		ev_d    = ev_q;
		idx_d   = idx_q;
		srch_go = 1'b0;
		map_ctrl = '0;
		map_ctrl.rd_addr = cur_q[sps_pkg::IDX_W-1:0];

		unique case (state_q)
			sps_pkg::S_EXEC: begin
				ev_d  = sps_pkg::EV_NONE;
				idx_d = '0;
				unique case (act_q)
					sps_pkg::ACT_MEASURE: begin
						int_d  = ic_new;
						scan_d = sa_new;
						cur_d  = cs_new;
						if (sa_new) begin
							if (awm_q) begin
								if (rlat_q && !busy_q) begin
									rlat_d = 1'b0;
									awm_d  = 1'b0;
									idx_d  = cs_new[sps_pkg::IDX_W-1:0];
									cur_d  = cs_inc;
									ev_d   = sps_pkg::EV_DATA;
								end else if (t10ms_q) begin
									mwc_d = mwc_inc;
									if (mwc_inc > TMO) begin
										awm_d = 1'b0;
										map_ctrl.clr_en   = (cs_new < NUM_S);
										map_ctrl.clr_addr = cs_new[sps_pkg::IDX_W-1:0];
										idx_d = cs_new[sps_pkg::IDX_W-1:0];
										cur_d = cs_inc;
										err_d = sps_pkg::ERR_MEAS_TO;
										ev_d  = sps_pkg::EV_MEAS_TIMEOUT;
									end
								end
							end else if (t10ms_q) begin
								srch_go = 1'b1;
							end
						end
					end
					sps_pkg::ACT_POLL: begin
						if (awp_q) begin
							if (rlat_q) begin
								rlat_d  = 1'b0;
								awp_d   = 1'b0;
								retry_d = '0;
								cur_d   = cur_inc;
							end else if (t10ms_q) begin
								pwc_d = pwc_inc;
								if (pwc_inc > TMO) begin
									retry_d = retry_inc;
									if (retry_inc == 2'd3) begin
										map_ctrl.clr_en   = (cur_q < NUM_S);
										map_ctrl.clr_addr = cur_q[sps_pkg::IDX_W-1:0];
										idx_d   = cur_q[sps_pkg::IDX_W-1:0];
										retry_d = '0;
										cur_d   = cur_inc;
										ev_d    = sps_pkg::EV_POLL_FAIL;
									end
									awp_d  = 1'b0;
									rlat_d = 1'b0;
									err_d  = sps_pkg::ERR_POLL_FAIL;
								end
							end
						end else if (!busy_q) begin
							srch_go = 1'b1;
						end
					end
					sps_pkg::ACT_INIT: begin
						cur_d  = '0;
						int_d  = scan_interval_q;
						rlat_d = 1'b0;
					end
					sps_pkg::ACT_RESP: begin
						rlat_d = resp_val_q;
					end
					sps_pkg::ACT_LOAD: begin
						map_ctrl.wr_en   = ({1'b0, lidx_q} < NUM_S);
						map_ctrl.wr_addr = lidx_q;
						map_ctrl.wr_data = lst_q;
					end
					default: ;
				endcase
			end

			// first read of the search, or end if already out of range
			sps_pkg::S_SRCH: begin
				if (!(cur_q < NUM_S)) begin
					cur_d = '0;
					if (act_q == sps_pkg::ACT_MEASURE) begin
						scan_d = 1'b0;
						ev_d   = sps_pkg::EV_SCAN_END;
					end else begin
						err_d = sps_pkg::ERR_NONE;
						ev_d  = sps_pkg::EV_POLL_DONE;
					end
				end
			end

			// check one entry per cycle, next one already being read
			sps_pkg::S_CHK: begin
				map_ctrl.rd_addr = cur_inc[sps_pkg::IDX_W-1:0];
				if (skip) begin
					cur_d = cur_inc;
					if (act_q == sps_pkg::ACT_POLL) retry_d = '0;
					if (!(cur_inc < NUM_S)) begin
						cur_d = '0;
						if (act_q == sps_pkg::ACT_MEASURE) begin
							scan_d = 1'b0;
							ev_d   = sps_pkg::EV_SCAN_END;
						end else begin
							err_d = sps_pkg::ERR_NONE;
							ev_d  = sps_pkg::EV_POLL_DONE;
						end
					end
				end else begin
					idx_d = cur_q[sps_pkg::IDX_W-1:0];
					if (act_q == sps_pkg::ACT_MEASURE) begin
						awm_d = 1'b1;
						mwc_d = '0;
						ev_d  = sps_pkg::EV_MEAS_CMD;
					end else begin
						awp_d = 1'b1;
						pwc_d = '0;
						ev_d  = sps_pkg::EV_POLL_CMD;
					end
				end
			end

			default: ;
		endcase
	end

	// request capture, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= req.action;
			t1s_q      <= req.tick_1s;
			t10ms_q    <= req.tick_10ms;
			busy_q     <= req.tx_busy;
			resp_val_q <= req.response_value;
			lidx_q     <= req.load_index;
			lst_q      <= req.load_status;
		end
	end

	// sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= sps_pkg::S_IDLE;
			scan_interval_q <= sps_pkg::SCAN_INTERVAL_RST;
			cur_q           <= '0;
			int_q           <= sps_pkg::SCAN_INTERVAL_RST;
			scan_q          <= 1'b0;
			awm_q           <= 1'b0;
			mwc_q           <= '0;
			awp_q           <= 1'b0;
			pwc_q           <= '0;
			retry_q         <= '0;
			rlat_q          <= 1'b0;
			err_q           <= sps_pkg::ERR_NONE;
			ev_q            <= sps_pkg::EV_NONE;
			idx_q           <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) scan_interval_q <= cfg_wr_data;
			cur_q   <= cur_d;
			int_q   <= int_d;
			scan_q  <= scan_d;
			awm_q   <= awm_d;
			mwc_q   <= mwc_d;
			awp_q   <= awp_d;
			pwc_q   <= pwc_d;
			retry_q <= retry_d;
			rlat_q  <= rlat_d;
			err_q   <= err_d;
			ev_q    <= ev_d;
			idx_q   <= idx_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == sps_pkg::S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sps_pkg::S_DONE && out_free) begin
			out_ev_q   <= ev_q;
			out_idx_q  <= idx_q;
			out_err_q  <= err_q;
			out_scan_q <= scan_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.event_res    = out_ev_q;
	assign rsp.sensor_index = out_idx_q;
	assign rsp.error_code   = out_err_q;
	assign rsp.scanning     = out_scan_q;

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for sensor_poll_scan_sequencer, predictor and scoreboard in one class
// needs sps_pkg, the sps_req_if / sps_rsp_if interfaces and the sequencer rtl

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sps_pkg::*;

	// status codes beyond the package ones, all counted as other
	localparam logic [1:0] ST_OTHER     = 2'd2;
	localparam logic [1:0] ST_OTHER_ALT = 2'd3;

	// action codes the block ignores
	localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

	localparam int END_DRAIN_CYCLES = 80;
	localparam int LONG_HOLD_CYCLES = 400;

	typedef struct packed {
		logic [2:0]       action;
		logic             tick_1s;
		logic             tick_10ms;
		logic             tx_busy;
		logic             response_value;
		logic [IDX_W-1:0] load_index;
		logic [1:0]       load_status;
	} step_req_t;

	typedef struct packed {
		logic [2:0]       event_res;
		logic [IDX_W-1:0] sensor_index;
		logic [1:0]       error_code;
		logic             scanning;
	} step_rsp_t;

	typedef enum int {
		MIX_MEASURE,
		MIX_POLL,
		MIX_BOTH,
		MIX_LOAD,
		MIX_NOISE,
		MIX_MEAS_STALL,
		MIX_POLL_STALL
	} stim_mode_e;

	// predicts each step of the sequencer and holds the pending results
	class sequencer_scoreboard;
		logic [1:0]       status_map [NUM_SENSORS];
		logic [CUR_W-1:0] cur_sensor;
		logic [CNT_W-1:0] interval_cnt;
		logic [CNT_W-1:0] scan_interval;
		logic             scan_on;
		logic             meas_pending;
		logic [CNT_W-1:0] meas_wait;
		logic             poll_pending;
		logic [CNT_W-1:0] poll_wait;
		logic [1:0]       retries;
		logic             resp_seen;
		logic [1:0]       err_state;
		step_rsp_t        expected_results [$];
		int               mismatch_count;

		function new();
			foreach (status_map[i])
				status_map[i] = ST_ABSENT;
			cur_sensor     = '0;
			scan_interval  = SCAN_INTERVAL_RST;
			interval_cnt   = SCAN_INTERVAL_RST;
			scan_on        = 1'b0;
			meas_pending   = 1'b0;
			meas_wait      = '0;
			poll_pending   = 1'b0;
			poll_wait      = '0;
			retries        = '0;
			resp_seen      = 1'b0;
			err_state      = ERR_NONE;
			mismatch_count = 0;
		endfunction

		function bit in_range(logic [CUR_W-1:0] i);
			return i < NUM_SENSORS;
		endfunction

		function void next_sensor();
			cur_sensor = cur_sensor + 1'b1;
		endfunction

		function void drop_sensor();
			if (in_range(cur_sensor))
				status_map[cur_sensor[IDX_W-1:0]] = ST_ABSENT;
		endfunction

		// measure step: interval countdown, command, data or timeout
		function void measure_step(step_req_t it, output logic [2:0] ev,
				output logic [IDX_W-1:0] idx);
			ev  = EV_NONE;
			idx = '0;
			if (it.tick_1s) begin
				interval_cnt = interval_cnt - 1'b1;
				if (interval_cnt == '0) begin
					interval_cnt = scan_interval;
					scan_on      = 1'b1;
					cur_sensor   = '0;
				end
			end
			if (!scan_on)
				return;
			if (meas_pending) begin
				if (resp_seen && !it.tx_busy) begin
					resp_seen    = 1'b0;
					meas_pending = 1'b0;
					idx          = cur_sensor[IDX_W-1:0];
					next_sensor();
					ev = EV_DATA;
					return;
				end
				if (it.tick_10ms) begin
					meas_wait = meas_wait + 1'b1;
					if (meas_wait > TIMEOUT_TICKS) begin
						meas_pending = 1'b0;
						drop_sensor();
						idx = cur_sensor[IDX_W-1:0];
						next_sensor();
						err_state = ERR_MEAS_TO;
						ev        = EV_MEAS_TIMEOUT;
					end
				end
				return;
			end
			if (!it.tick_10ms)
				return;
			while (in_range(cur_sensor) && status_map[cur_sensor[IDX_W-1:0]] == ST_ABSENT)
				next_sensor();
			if (!in_range(cur_sensor)) begin
				cur_sensor = '0;
				scan_on    = 1'b0;
				ev         = EV_SCAN_END;
				return;
			end
			meas_pending = 1'b1;
			meas_wait    = '0;
			idx          = cur_sensor[IDX_W-1:0];
			ev           = EV_MEAS_CMD;
		endfunction

		// poll setup step: command, retry on timeout, fail after three tries
		function void poll_step(step_req_t it, output logic [2:0] ev,
				output logic [IDX_W-1:0] idx);
			ev  = EV_NONE;
			idx = '0;
			if (poll_pending) begin
				if (resp_seen) begin
					resp_seen    = 1'b0;
					poll_pending = 1'b0;
					retries      = '0;
					next_sensor();
					return;
				end
				if (it.tick_10ms) begin
					poll_wait = poll_wait + 1'b1;
					if (poll_wait > TIMEOUT_TICKS) begin
						retries = retries + 1'b1;
						if (retries > 2'd2) begin
							drop_sensor();
							idx     = cur_sensor[IDX_W-1:0];
							retries = '0;
							next_sensor();
							ev = EV_POLL_FAIL;
						end
						poll_pending = 1'b0;
						resp_seen    = 1'b0;
						err_state    = ERR_POLL_FAIL;
					end
				end
				return;
			end
			if (it.tx_busy)
				return;
			while (in_range(cur_sensor) && status_map[cur_sensor[IDX_W-1:0]] != ST_PRESENT) begin
				retries = '0;
				next_sensor();
			end
			if (!in_range(cur_sensor)) begin
				cur_sensor = '0;
				err_state  = ERR_NONE;
				ev         = EV_POLL_DONE;
				return;
			end
			poll_pending = 1'b1;
			poll_wait    = '0;
			idx          = cur_sensor[IDX_W-1:0];
			ev           = EV_POLL_CMD;
		endfunction

		// accepted request: advance the model and queue its result
		function void note_request(step_req_t it);
			logic [2:0]       ev;
			logic [IDX_W-1:0] idx;
			step_rsp_t        r;
			ev  = EV_NONE;
			idx = '0;
			case (it.action)
				ACT_MEASURE: measure_step(it, ev, idx);
				ACT_POLL:    poll_step(it, ev, idx);
				ACT_INIT: begin
					cur_sensor   = '0;
					interval_cnt = scan_interval;
					resp_seen    = 1'b0;
				end
				ACT_RESP: resp_seen = it.response_value;
				ACT_LOAD: begin
					if (in_range({1'b0, it.load_index}))
						status_map[it.load_index] = it.load_status;
				end
				default: ;
			endcase
			r.event_res    = ev;
			r.sensor_index = idx;
			r.error_code   = err_state;
			r.scanning     = scan_on;
			expected_results.push_back(r);
		endfunction

		task report_mismatch(string msg);
			mismatch_count++;
			if (mismatch_count <= 100)
				$display("%0t ns mismatch: %s", $time, msg);
		endtask

		// accepted result: compare with the oldest pending one
		task check_result(step_rsp_t got);
			step_rsp_t want;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result, event %0d sensor %0d",
					got.event_res, got.sensor_index));
				return;
			end
			want = expected_results.pop_front();
			if (got.event_res !== want.event_res)
				report_mismatch($sformatf("event_res %0d, want %0d",
					got.event_res, want.event_res));
			if (got.sensor_index !== want.sensor_index)
				report_mismatch($sformatf("sensor_index %0d, want %0d",
					got.sensor_index, want.sensor_index));
			if (got.error_code !== want.error_code)
				report_mismatch($sformatf("error_code %0d, want %0d",
					got.error_code, want.error_code));
			if (got.scanning !== want.scanning)
				report_mismatch($sformatf("scanning %0d, want %0d",
					got.scanning, want.scanning));
		endtask
	endclass

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;

	sps_req_if req_if();
	sps_rsp_if rsp_if();

	sensor_poll_scan_sequencer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_if),
		.rsp         (rsp_if)
	);

	sequencer_scoreboard sb = new();

	int burst_left    = 0;
	bit long_hold_req = 1'b0;

	// clock
	always #6 clk = ~clk;

	// run limit
	initial begin
		#12_000_000;
		$display("sensor_poll_scan_sequencer regression: fail");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
			sb.check_result({rsp_if.event_res, rsp_if.sensor_index,
				rsp_if.error_code, rsp_if.scanning});
	end

	// receiver: stall pattern in changing modes, long hold-off on request
	initial begin
		int rx_mode;
		int rx_left;
		rx_mode = 0;
		rx_left = 0;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 2);
					rx_left = $urandom_range(20, 200);
				end
				rx_left--;
				case (rx_mode)
					0:       rsp_if.ready <= 1'b1;
					1:       rsp_if.ready <= 1'($urandom_range(0, 1));
					default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// one request, in bursts with random gaps between them
	task automatic send_req(step_req_t it);
		if (burst_left == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req_if.valid          <= 1'b1;
		req_if.action         <= it.action;
		req_if.tick_1s        <= it.tick_1s;
		req_if.tick_10ms      <= it.tick_10ms;
		req_if.tx_busy        <= it.tx_busy;
		req_if.response_value <= it.response_value;
		req_if.load_index     <= it.load_index;
		req_if.load_status    <= it.load_status;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		sb.note_request(it);
	endtask

	task automatic send_step(logic [2:0] act, logic t1s, logic t10ms, logic busy,
			logic resp, logic [IDX_W-1:0] lidx, logic [1:0] lst);
		send_req({act, t1s, t10ms, busy, resp, lidx, lst});
	endtask

	// stop offering requests until every pending result is back
	task automatic wait_for_results();
		req_if.valid <= 1'b0;
		burst_left = 0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_interval(logic [CNT_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.scan_interval = value;
	endtask

	// random request shaped by the kind of sequence being run
	function automatic step_req_t make_item(stim_mode_e mode);
		step_req_t it;
		int        roll;
		it.action         = 3'($urandom_range(0, 7));
		it.tick_1s        = 1'($urandom_range(0, 1));
		it.tick_10ms      = 1'($urandom_range(0, 1));
		it.tx_busy        = 1'($urandom_range(0, 1));
		it.response_value = 1'($urandom_range(0, 1));
		it.load_index     = IDX_W'($urandom_range(0, 63));
		it.load_status    = 2'($urandom_range(0, 3));
		roll = $urandom_range(0, 99);
		case (mode)
			MIX_MEASURE: begin
				if (roll < 55)      it.action = ACT_MEASURE;
				else if (roll < 80) it.action = ACT_RESP;
				else if (roll < 88) it.action = ACT_LOAD;
				else if (roll < 93) it.action = ACT_INIT;
				it.tick_1s        = ($urandom_range(0, 3) == 0);
				it.tick_10ms      = ($urandom_range(0, 3) != 0);
				it.tx_busy        = ($urandom_range(0, 3) == 0);
				it.response_value = ($urandom_range(0, 4) != 0);
			end
			MIX_POLL: begin
				if (roll < 55)      it.action = ACT_POLL;
				else if (roll < 80) it.action = ACT_RESP;
				else if (roll < 88) it.action = ACT_LOAD;
				else if (roll < 93) it.action = ACT_INIT;
				it.tick_10ms      = ($urandom_range(0, 3) != 0);
				it.tx_busy        = ($urandom_range(0, 3) == 0);
				it.response_value = ($urandom_range(0, 4) != 0);
			end
			MIX_BOTH: begin
				if (roll < 35)      it.action = ACT_MEASURE;
				else if (roll < 65) it.action = ACT_POLL;
				else if (roll < 88) it.action = ACT_RESP;
				else if (roll < 95) it.action = ACT_LOAD;
				it.tick_1s        = ($urandom_range(0, 3) == 0);
				it.tick_10ms      = ($urandom_range(0, 3) != 0);
				it.tx_busy        = ($urandom_range(0, 3) == 0);
				it.response_value = ($urandom_range(0, 4) != 0);
			end
			MIX_LOAD: begin
				it.action = ACT_LOAD;
				if (roll < 50)
					it.load_status = ST_PRESENT;
				if ($urandom_range(0, 3) == 0)
					it.load_index = $urandom_range(0, 1) ? IDX_W'(NUM_SENSORS - 1) : '0;
			end
			MIX_MEAS_STALL: begin
				it.action    = ACT_MEASURE;
				it.tick_10ms = 1'b1;
				it.tick_1s   = ($urandom_range(0, 15) == 0);
			end
			MIX_POLL_STALL: begin
				it.action    = ACT_POLL;
				it.tick_10ms = 1'b1;
			end
			default: ;
		endcase
		return it;
	endfunction

	task automatic run_mix(stim_mode_e mode, int count);
		repeat (count) send_req(make_item(mode));
	endtask

	// main sequence
	initial begin
		int         intervals [6];
		int         sent;
		int         n;
		stim_mode_e mode;
		intervals = '{2, 255, 1, 0, 3, 10};

		req_if.valid          <= 1'b0;
		req_if.action         <= ACT_MEASURE;
		req_if.tick_1s        <= 1'b0;
		req_if.tick_10ms      <= 1'b0;
		req_if.tx_busy        <= 1'b0;
		req_if.response_value <= 1'b0;
		req_if.load_index     <= '0;
		req_if.load_status    <= ST_ABSENT;
		cfg_wr_en             <= 1'b0;
		cfg_wr_data           <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: map loads, ignored actions, a full poll pass, default interval
		send_step(ACT_LOAD, 1'b1, 1'b0, 1'b1, 1'b1, '0, ST_PRESENT);
		send_step(ACT_LOAD, 1'b0, 1'b1, 1'b0, 1'b0, 6'd63, ST_PRESENT);
		send_step(ACT_LOAD, 1'b0, 1'b0, 1'b0, 1'b0, 6'd5, ST_OTHER_ALT);
		send_step(ACT_LOAD, 1'b0, 1'b0, 1'b0, 1'b0, 6'd62, ST_OTHER);
		send_step(ACT_UNUSED_LO, 1'b1, 1'b1, 1'b1, 1'b1, 6'd63, ST_OTHER_ALT);
		send_step(ACT_UNUSED_HI, 1'b1, 1'b1, 1'b0, 1'b1, 6'd1, ST_PRESENT);
		send_step(ACT_POLL, 1'b0, 1'b0, 1'b1, 1'b0, '0, ST_ABSENT);
		send_step(ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b0, '0, ST_ABSENT);
		send_step(ACT_RESP, 1'b0, 1'b0, 1'b0, 1'b1, '0, ST_ABSENT);
		send_step(ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b0, '0, ST_ABSENT);
		send_step(ACT_POLL, 1'b0, 1'b1, 1'b0, 1'b0, '0, ST_ABSENT);
		send_step(ACT_RESP, 1'b0, 1'b0, 1'b0, 1'b0, '0, ST_ABSENT);
		send_step(ACT_RESP, 1'b0, 1'b0, 1'b0, 1'b1, '0, ST_ABSENT);
		send_step(ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b0, '0, ST_ABSENT);
		send_step(ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b0, '0, ST_ABSENT);
		send_step(ACT_MEASURE, 1'b1, 1'b1, 1'b0, 1'b0, '0, ST_ABSENT);

		// directed: shortest interval, scan start, busy hold, data, restart mid scan
		wait_for_results();
		write_interval(8'd1);
		send_step(ACT_INIT, 1'b0, 1'b0, 1'b0, 1'b0, '0, ST_ABSENT);
		send_step(ACT_MEASURE, 1'b1, 1'b1, 1'b0, 1'b0, '0, ST_ABSENT);
		send_step(ACT_RESP, 1'b0, 1'b0, 1'b0, 1'b1, '0, ST_ABSENT);
		send_step(ACT_MEASURE, 1'b0, 1'b0, 1'b1, 1'b0, '0, ST_ABSENT);
		send_step(ACT_MEASURE, 1'b0, 1'b0, 1'b0, 1'b0, '0, ST_ABSENT);
		send_step(ACT_MEASURE, 1'b0, 1'b1, 1'b0, 1'b0, '0, ST_ABSENT);
		send_step(ACT_MEASURE, 1'b1, 1'b0, 1'b0, 1'b0, '0, ST_ABSENT);
		send_step(ACT_RESP, 1'b0, 1'b0, 1'b0, 1'b1, '0, ST_ABSENT);
		send_step(ACT_MEASURE, 1'b0, 1'b0, 1'b0, 1'b0, '0, ST_ABSENT);

		// random phases, one interval setting each
		for (int p = 0; p < 6; p++) begin
			wait_for_results();
			write_interval(CNT_W'(intervals[p]));
			if (p == 1)
				long_hold_req = 1'b1;
			run_mix(MIX_LOAD, $urandom_range(10, 20));
			sent = 0;
			while (sent < 20) begin
				mode = stim_mode_e'($urandom_range(0, 4));
				n    = $urandom_range(5, 25);
				run_mix(mode, n);
				sent += n;
			end
			// unanswered measure command runs into its timeout
			if (p == 2)
				run_mix(MIX_MEAS_STALL, 110);
			// three unanswered poll attempts in a row
			if (p == 4)
				run_mix(MIX_POLL_STALL, 330);
		end

		wait_for_results();
		repeat (END_DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_results.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived",
				sb.expected_results.size()));
		if (sb.mismatch_count == 0) begin
			$display("sensor_poll_scan_sequencer regression: pass");
		end else begin
			$display("sensor_poll_scan_sequencer regression: fail");
		end
		$finish;
	end

endmodule
